### design/cfte_pkg.sv
package cfte_pkg;

    localparam int NEST_DEPTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        CMD_FIELD  = 3'd0,
        CMD_ZIGZAG = 3'd1,
        CMD_UVAR   = 3'd2,
        CMD_LIST   = 3'd3,
        CMD_BEGIN  = 3'd4,
        CMD_END    = 3'd5,
        CMD_STOP   = 3'd6,
        CMD_RAW    = 3'd7
    } t_cmd;

    localparam logic [3:0] LIST_LONG_NIBBLE = 4'hF;
    localparam logic [3:0] LIST_SHORT_MAX   = 4'd14;

    typedef struct packed {
        logic        err;
        logic        has_head;
        logic [7:0]  head;
        logic        has_vint;
        logic [63:0] vint;
    } t_job;

endpackage

### design/cfte_front.sv
module cfte_front #(
    parameter int NEST_DEPTH = cfte_pkg::NEST_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_command,
    input  logic [15:0]     i_field_id,
    input  logic [3:0]      i_type_code,
    input  logic [63:0]     i_value,
    input  logic [30:0]     i_list_count,
    input  logic [7:0]      i_raw_byte,
    input  logic            i_full,
    output logic            o_push,
    output cfte_pkg::t_job  o_job
);

    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    logic [15:0]   r_last_id, n_last_id;
    logic [LW-1:0] r_level, n_level;
    logic          r_pend;
    logic [15:0]   r_rd;
    logic [15:0]   r_stack [NEST_DEPTH];

    logic          accept;
    logic          do_push;
    logic          do_pop;
    logic [LW-1:0] level_m1;
    logic [16:0]   delta;
    logic [16:0]   zz_id;
    logic [63:0]   zz_value;
    logic          delta_short;
    logic          list_short;
    cfte_pkg::t_cmd cmd;

    assign o_ready     = !i_full && !r_pend;
    assign accept      = i_valid && o_ready;
    assign cmd         = cfte_pkg::t_cmd'(i_command);
    assign level_m1    = r_level - LW'(1);
    assign delta       = {i_field_id[15], i_field_id} - {r_last_id[15], r_last_id};
    assign zz_id       = {i_field_id, 1'b0} ^ {17{i_field_id[15]}};
    assign zz_value    = {i_value[62:0], 1'b0} ^ {64{i_value[63]}};
    assign delta_short = (delta[16:4] == 13'd0) && (delta[3:0] != 4'd0);
    assign list_short  = (i_list_count[30:4] == 27'd0)
                         && (i_list_count[3:0] <= cfte_pkg::LIST_SHORT_MAX);

    always_comb begin
        o_job     = '0;
        o_push    = 1'b0;
        n_last_id = r_last_id;
        n_level   = r_level;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        if (accept) begin
            unique case (cmd)
                cfte_pkg::CMD_FIELD: begin
                    o_push         = 1'b1;
                    o_job.has_head = 1'b1;
                    n_last_id      = i_field_id;
                    if (delta_short) begin
                        o_job.head = {delta[3:0], i_type_code};
                    end else begin
                        o_job.head     = {4'd0, i_type_code};
                        o_job.has_vint = 1'b1;
                        o_job.vint     = {47'd0, zz_id};
                    end
                end
                cfte_pkg::CMD_ZIGZAG: begin
                    o_push         = 1'b1;
                    o_job.has_vint = 1'b1;
                    o_job.vint     = zz_value;
                end
                cfte_pkg::CMD_UVAR: begin
                    o_push         = 1'b1;
                    o_job.has_vint = 1'b1;
                    o_job.vint     = i_value;
                end
                cfte_pkg::CMD_LIST: begin
                    o_push         = 1'b1;
                    o_job.has_head = 1'b1;
                    if (list_short) begin
                        o_job.head = {i_list_count[3:0], i_type_code};
                    end else begin
                        o_job.head     = {cfte_pkg::LIST_LONG_NIBBLE, i_type_code};
                        o_job.has_vint = 1'b1;
                        o_job.vint     = {33'd0, i_list_count};
                    end
                end
                cfte_pkg::CMD_BEGIN: begin
                    if (r_level >= LW'(NEST_DEPTH)) begin
                        o_push         = 1'b1;
                        o_job.has_head = 1'b1;
                        o_job.err      = 1'b1;
                    end else begin
                        do_push   = 1'b1;
                        n_level   = r_level + LW'(1);
                        n_last_id = 16'd0;
                    end
                end
                cfte_pkg::CMD_END: begin
                    if (r_level == '0) begin
                        o_push         = 1'b1;
                        o_job.has_head = 1'b1;
                        o_job.err      = 1'b1;
                    end else begin
                        do_pop  = 1'b1;
                        n_level = level_m1;
                    end
                end
                cfte_pkg::CMD_STOP: begin
                    o_push         = 1'b1;
                    o_job.has_head = 1'b1;
                end
                cfte_pkg::CMD_RAW: begin
                    o_push         = 1'b1;
                    o_job.has_head = 1'b1;
                    o_job.head     = i_raw_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_stack[r_level[AW-1:0]] <= r_last_id;
        end
        if (do_pop) begin
            r_rd <= r_stack[level_m1[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_id <= 16'd0;
            r_level   <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_pend  <= do_pop;
            r_level <= n_level;
            if (r_pend) begin
                r_last_id <= r_rd;
            end else begin
                r_last_id <= n_last_id;
            end
        end
    end

endmodule

### design/cfte_fifo.sv
module cfte_fifo #(
    parameter int DEPTH = cfte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfte_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output cfte_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cfte_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rdp;
    logic [CW-1:0]  r_count;
    logic           wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_job   = r_mem[r_rdp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rdp   <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rdp <= (r_rdp == AW'(DEPTH - 1)) ? '0 : r_rdp + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

### design/cfte_back.sv
module cfte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cfte_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic            o_err
);

    logic        r_active;
    logic        r_head_pend;
    logic [7:0]  r_head;
    logic        r_vint_pend;
    logic [63:0] r_vint;
    logic        r_err;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_oerr;

    logic        advance;
    logic        vint_more;
    logic [7:0]  cur_byte;
    logic        cur_last;

    assign advance   = !r_ovalid || i_ready;
    assign o_pop     = !r_active && !i_empty;
    assign vint_more = |r_vint[63:7];

    always_comb begin
        if (r_head_pend) begin
            cur_byte = r_head;
            cur_last = !r_vint_pend;
        end else begin
            cur_byte = {vint_more, r_vint[6:0]};
            cur_last = !vint_more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_head <= i_job.head;
            r_err  <= i_job.err;
            r_vint <= i_job.vint;
        end else if (r_active && advance && !r_head_pend) begin
            r_vint <= {7'd0, r_vint[63:7]};
        end
        if (r_active && advance) begin
            r_obyte <= cur_byte;
            r_olast <= cur_last;
            r_oerr  <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_head_pend <= 1'b0;
            r_vint_pend <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active    <= 1'b1;
                r_head_pend <= i_job.has_head;
                r_vint_pend <= i_job.has_vint;
            end else if (r_active && advance) begin
                r_head_pend <= 1'b0;
                if (cur_last) begin
                    r_active    <= 1'b0;
                    r_vint_pend <= 1'b0;
                end
            end
            if (advance) begin
                r_ovalid <= r_active;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_err   = r_oerr;

endmodule

### design/compact_field_token_encoder.sv
// The first byte of a token passes through the queue entry, the byte engine's load registers
// and the output register. The byte engine sends one byte a cycle while the output is ready and
// takes the next token only once the last byte of the current one is sent; a struct end holds
// the input while the nest stack memory is read. Tokens that produce no byte are not queued.
// Reset is synchronous and active low; it clears the field id, nest level and queue, while
// the nest stack contents stay undefined and are never cleared.
module compact_field_token_encoder #(
    parameter int NEST_DEPTH  = cfte_pkg::NEST_DEPTH_DEF,
    parameter int QUEUE_DEPTH = cfte_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // field_id [15:0], type_code [19:16], value [83:20], list_count [114:84],
    // raw_byte [122:115], zero [127:123]
    input  logic [127:0] i_s_axis_tdata,
    // command [2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_byte [7:0]
    output logic [7:0]   o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    // nest_error [0]
    output logic         o_m_axis_tuser
);

    cfte_pkg::t_job front_job;
    cfte_pkg::t_job queue_job;
    logic           front_push;
    logic           queue_full;
    logic           queue_empty;
    logic           back_pop;

    cfte_front #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_command    (i_s_axis_tuser),
        .i_field_id   (i_s_axis_tdata[15:0]),
        .i_type_code  (i_s_axis_tdata[19:16]),
        .i_value      (i_s_axis_tdata[83:20]),
        .i_list_count (i_s_axis_tdata[114:84]),
        .i_raw_byte   (i_s_axis_tdata[122:115]),
        .i_full       (queue_full),
        .o_push       (front_push),
        .o_job        (front_job)
    );

    cfte_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_job   (queue_job),
        .o_empty (queue_empty)
    );

    cfte_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (queue_empty),
        .i_job   (queue_job),
        .o_pop   (back_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast),
        .o_err   (o_m_axis_tuser)
    );

endmodule
